// ===== src/fsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants for the frustum sphere cull block
// Item formats, plane count and result codes used by every module but the queue.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int DATA_W     = 32;
  localparam int NUM_PLANES = 6;
  localparam int NUM_ELEMS  = 16;
  localparam int NUM_COMPS  = 4;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_TEST    = 1'b1;
  localparam logic [2:0] PLANE_NONE = 3'd6;

  typedef logic signed [DATA_W-1:0] fix_t;

  typedef struct packed {
    logic       op;
    logic [3:0] elem_index;
    fix_t       elem_value;
    fix_t       center_x;
    fix_t       center_y;
    fix_t       center_z;
    fix_t       radius;
  } cmd_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] failing_plane;
  } res_t;

  typedef struct packed {
    logic       we;
    logic [2:0] idx;
  } plane_wr_t;

endpackage
`default_nettype wire

// ===== src/fsc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_queue: small register FIFO
// Push/full on the write side, pop/empty on the read side, data shown at head.
// ----------------------------------------------------------------------------
module fsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule
`default_nettype wire

// ===== src/fsc_plane_build.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_plane_build: frustum plane extraction and normalization
// Per plane: saturated row sums, squared length, bit-serial square root and
// one bit-serial divide per component unless the length is zero.
// ----------------------------------------------------------------------------
module fsc_plane_build
  import fsc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  fix_t      matrix [NUM_ELEMS],
  output plane_wr_t wr,
  output fix_t      wr_data [NUM_COMPS],
  output logic      done
);

  localparam int DW     = DATA_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DW);

  typedef enum logic [2:0] {
    S_IDLE, S_RAW, S_SQ, S_ROOT, S_LEN, S_DINIT, S_DIV, S_WRITE
  } state_t;

  state_t           state_r;
  logic [2:0]       plane_r;
  logic [1:0]       comp_r;
  logic [STEP_W-1:0] step_r;
  fix_t             raw_r  [NUM_COMPS];
  fix_t             norm_r [NUM_COMPS];
  logic [63:0]      sq_prod_r, acc_r, x_r, res_r, bit_r;
  logic [DW-1:0]    dvd_r, quo_r;
  logic [DATA_W-1:0] rem_r;

  fix_t              raw_nxt [NUM_COMPS];
  logic signed [63:0] sq;
  logic [63:0]       trial;
  logic [DATA_W-1:0] len, mag;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DW-1:0]     q_fin;
  fix_t              q_sat;

  function automatic fix_t sat33(input logic signed [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1]) return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                   : {1'b0, {(DATA_W-1){1'b1}}};
    return v[DATA_W-1:0];
  endfunction

  // row 3 plus or minus row k, k = plane / 2
  always_comb begin
    logic signed [DATA_W:0] a, b;
    for (int c = 0; c < NUM_COMPS; c++) begin
      a = {matrix[12 + c][DATA_W-1], matrix[12 + c]};
      b = {matrix[{plane_r[2:1], 2'(c)}][DATA_W-1], matrix[{plane_r[2:1], 2'(c)}]};
      raw_nxt[c] = sat33(plane_r[0] ? a - b : a + b);
    end
  end

  assign sq    = raw_r[comp_r] * raw_r[comp_r];
  assign trial = res_r + bit_r;
  assign len   = res_r[DATA_W-1:0];
  assign mag   = raw_r[comp_r][DATA_W-1] ? (~raw_r[comp_r] + DATA_W'(1)) : raw_r[comp_r];
  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign ge     = (rem_sh >= {1'b0, len});
  assign q_fin  = {quo_r[DW-2:0], ge};

  always_comb begin
    if (raw_r[comp_r][DATA_W-1]) begin
      if (q_fin[DW-1:DATA_W] != '0 || (q_fin[DATA_W-1] && q_fin[DATA_W-2:0] != '0))
        q_sat = {1'b1, {(DATA_W-1){1'b0}}};
      else
        q_sat = -q_fin[DATA_W-1:0];
    end else begin
      if (q_fin[DW-1:DATA_W-1] != '0) q_sat = {1'b0, {(DATA_W-1){1'b1}}};
      else q_sat = q_fin[DATA_W-1:0];
    end
  end

  assign wr.we   = (state_r == S_WRITE);
  assign wr.idx  = plane_r;
  assign wr_data = norm_r;
  assign done    = (state_r == S_WRITE) && (plane_r == 3'(NUM_PLANES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plane_r <= '0;
      comp_r  <= '0;
      step_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            plane_r <= '0;
            state_r <= S_RAW;
          end
        end
        S_RAW: begin
          raw_r   <= raw_nxt;
          acc_r   <= '0;
          comp_r  <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (comp_r != 2'd3) sq_prod_r <= 64'(sq);
          if (comp_r != 2'd0) acc_r <= acc_r + sq_prod_r;
          if (comp_r == 2'd3) begin
            x_r     <= acc_r + sq_prod_r;
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            step_r  <= STEP_W'(31);
            state_r <= S_ROOT;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_ROOT: begin
          if (x_r >= trial) begin
            x_r   <= x_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) state_r <= S_LEN;
        end
        S_LEN: begin
          comp_r <= '0;
          if (len == '0) begin
            norm_r  <= raw_r;
            state_r <= S_WRITE;
          end else begin
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          dvd_r   <= {mag, {FRAC_BITS{1'b0}}};
          rem_r   <= '0;
          quo_r   <= '0;
          step_r  <= STEP_W'(DW - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= ge ? DATA_W'(rem_sh - {1'b0, len}) : rem_sh[DATA_W-1:0];
          quo_r  <= q_fin;
          dvd_r  <= dvd_r << 1;
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            norm_r[comp_r] <= q_sat;
            if (comp_r == 2'd3) begin
              state_r <= S_WRITE;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_DINIT;
            end
          end
        end
        S_WRITE: begin
          if (plane_r == 3'(NUM_PLANES - 1)) begin
            state_r <= S_IDLE;
          end else begin
            plane_r <= plane_r + 3'd1;
            state_r <= S_RAW;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/fsc_sphere_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_sphere_test: sphere against six planes, one plane per cycle
// Two-stage dot unit: three products registered, then exact signed sum.
// ----------------------------------------------------------------------------
module fsc_sphere_test
  import fsc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  cmd_t      cmd,
  input  fix_t      planes [NUM_PLANES][NUM_COMPS],
  output res_t      result,
  output logic      done
);

  localparam int SHW   = DATA_W + 1 + FRAC_BITS;
  localparam int ACC_W = ((SHW > 2 * DATA_W) ? SHW : 2 * DATA_W) + 3;

  logic               busy_r, p1_vld_r;
  logic [2:0]         issue_r, p1_idx_r, fp;
  fix_t               ctr_r [3];
  fix_t               rad_r;
  logic signed [2*DATA_W-1:0] prod_r [3];
  logic signed [DATA_W:0]     dr_r;
  logic [NUM_PLANES-1:0]      fail_r;
  logic signed [ACC_W-1:0]    sum;

  assign sum = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
             + (ACC_W'(dr_r) <<< FRAC_BITS);

  always_comb begin
    fp = PLANE_NONE;
    for (int i = NUM_PLANES - 1; i >= 0; i--)
      if (fail_r[i]) fp = 3'(i);
  end

  assign done                 = busy_r && (issue_r == 3'(NUM_PLANES)) && !p1_vld_r;
  assign result.visible       = (fail_r == '0);
  assign result.failing_plane = fp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      p1_vld_r <= 1'b0;
      issue_r  <= '0;
      fail_r   <= '0;
    end else begin
      p1_vld_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        issue_r <= '0;
        fail_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r && issue_r != 3'(NUM_PLANES)) begin
        p1_vld_r <= 1'b1;
        issue_r  <= issue_r + 3'd1;
      end
      if (p1_vld_r) fail_r[p1_idx_r] <= (sum < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ctr_r[0] <= cmd.center_x;
      ctr_r[1] <= cmd.center_y;
      ctr_r[2] <= cmd.center_z;
      rad_r    <= cmd.radius[DATA_W-1] ? '0 : cmd.radius;
    end
    if (busy_r && issue_r != 3'(NUM_PLANES)) begin
      for (int c = 0; c < 3; c++)
        prod_r[c] <= planes[issue_r][c] * ctr_r[c];
      dr_r     <= {planes[issue_r][3][DATA_W-1], planes[issue_r][3]} + {1'b0, rad_r};
      p1_idx_r <= issue_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/frustum_sphere_cull.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_sphere_cull: frustum plane extraction and sphere culling
// Loads a view-projection matrix element by element, rebuilds six normalized
// planes after each load, and tests spheres against them.
// ----------------------------------------------------------------------------
// Test item: in the back end, from dequeue to result, the six plane issues
//   on the shared dot unit, the sum stage and the decision; the back end then
//   returns to idle before it takes the next item, so spheres do not overlap.
// Load item: from dequeue to result, each of the six planes runs the
//   bit-serial square root and its four bit-serial divides;
//   a zero-length plane skips its divides.
// Reset (synchronous, rst_n low) clears both queues, the matrix and the
//   planes to zero; no clearing pass is needed.
module frustum_sphere_cull
  import fsc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic              in_op,
  input  wire logic [3:0]        in_elem_index,
  input  wire logic signed [31:0] in_elem_value,
  input  wire logic signed [31:0] in_center_x,
  input  wire logic signed [31:0] in_center_y,
  input  wire logic signed [31:0] in_center_z,
  input  wire logic signed [31:0] in_radius,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_visible,
  output logic [2:0]             out_failing_plane
);

  typedef enum logic [1:0] {B_IDLE, B_BUILD, B_TEST} bstate_t;

  bstate_t   state_r;
  fix_t      mat_r   [NUM_ELEMS];
  fix_t      plane_r [NUM_PLANES][NUM_COMPS];

  cmd_t      in_cmd, q_cmd;
  logic      q_empty, q_pop;
  res_t      res_din, res_dout, test_res;
  logic      res_push, res_full;
  logic      build_start, build_done, test_start, test_done;
  plane_wr_t pwr;
  fix_t      pwr_data [NUM_COMPS];

  // Front end: items are queued as they arrive, regardless of kind.
  assign in_cmd = '{op: in_op, elem_index: in_elem_index, elem_value: in_elem_value,
                    center_x: in_center_x, center_y: in_center_y,
                    center_z: in_center_z, radius: in_radius};

  fsc_queue #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk, .rst_n,
    .push (in_push), .din (in_cmd), .full (in_full),
    .pop  (q_pop),   .dout (q_cmd), .empty (q_empty)
  );

  // Back end takes one item when idle and a result slot is free, so the
  // result push at the end never meets a full queue.
  assign q_pop       = (state_r == B_IDLE) && !q_empty && !res_full;
  assign build_start = q_pop && (q_cmd.op == OP_LOAD);
  assign test_start  = q_pop && (q_cmd.op == OP_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (build_start) state_r <= B_BUILD;
          else if (test_start) state_r <= B_TEST;
        end
        B_BUILD: if (build_done) state_r <= B_IDLE;
        B_TEST:  if (test_done) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Matrix and plane stores; the builder starts on the cycle after the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ELEMS; i++) mat_r[i] <= '0;
      for (int p = 0; p < NUM_PLANES; p++)
        for (int c = 0; c < NUM_COMPS; c++) plane_r[p][c] <= '0;
    end else begin
      if (build_start) mat_r[q_cmd.elem_index] <= q_cmd.elem_value;
      if (pwr.we) plane_r[pwr.idx] <= pwr_data;
    end
  end

  fsc_plane_build #(.FRAC_BITS(FRAC_BITS)) u_build (
    .clk, .rst_n,
    .start (build_start), .matrix (mat_r),
    .wr (pwr), .wr_data (pwr_data), .done (build_done)
  );

  fsc_sphere_test #(.FRAC_BITS(FRAC_BITS)) u_test (
    .clk, .rst_n,
    .start (test_start), .cmd (q_cmd), .planes (plane_r),
    .result (test_res), .done (test_done)
  );

  // Load items report not visible, no failing plane.
  assign res_push = (state_r == B_BUILD && build_done) || (state_r == B_TEST && test_done);
  assign res_din  = (state_r == B_TEST) ? test_res : '{visible: 1'b0, failing_plane: PLANE_NONE};

  fsc_queue #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk, .rst_n,
    .push (res_push), .din (res_din), .full (res_full),
    .pop  (out_pop),  .dout (res_dout), .empty (out_empty)
  );

  assign out_visible       = res_dout.visible;
  assign out_failing_plane = res_dout.failing_plane;

  // A result is only pushed into a slot reserved at dequeue.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // Done strobes only come from the unit that owns the current item.
  a_build_owner: assert property (@(posedge clk) disable iff (!rst_n)
    build_done |-> state_r == B_BUILD) else $error("stray plane build done");

  a_test_owner: assert property (@(posedge clk) disable iff (!rst_n)
    test_done |-> state_r == B_TEST) else $error("stray sphere test done");

  // Planes are never rewritten while a sphere test is running.
  a_no_write_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_TEST |-> !pwr.we) else $error("plane write during test");

endmodule
`default_nettype wire
